>>> hw/rtl/psa_pkg.sv
package psa_pkg;

	localparam int unsigned MAX_VOICES = 64;
	localparam int unsigned ROM_NOTES = 25;
	localparam logic [15:0] FULL_SCALE = 16'h8000;
	localparam logic [17:0] PHASE_STEP = 18'd256;
	localparam logic signed [20:0] OUT_MAX = 21'sd262143;
	localparam logic signed [20:0] OUT_MIN = -21'sd262144;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_NOTE = 1'b1;

	localparam logic [1:0] REG_ATTACK  = 2'd0;
	localparam logic [1:0] REG_DECAY   = 2'd1;
	localparam logic [1:0] REG_SUSTAIN = 2'd2;
	localparam logic [1:0] REG_RELEASE = 2'd3;

	typedef logic [16:0] period_t;
	typedef period_t period_tbl_t [MAX_VOICES];

	typedef struct packed {
		logic        held;
		logic [31:0] trig;
		logic [16:0] phase;
	} voice_t;

	typedef period_t rom_t [ROM_NOTES];

	localparam rom_t PERIOD_ROM = '{
		17'd62624, 17'd59109, 17'd55791, 17'd52660, 17'd49705, 17'd46915, 17'd44282,
		17'd41796, 17'd39451, 17'd37236, 17'd35146, 17'd33174, 17'd31312, 17'd29555,
		17'd27896, 17'd26330, 17'd24852, 17'd23457, 17'd22141, 17'd20898, 17'd19725,
		17'd18618, 17'd17573, 17'd16587, 17'd15656
	};

	function automatic period_tbl_t build_periods();
		period_tbl_t tbl;
		logic [17:0] tmp;
		for (int i = 0; i < MAX_VOICES; i++) begin
			if (i < ROM_NOTES) begin
				tbl[i] = PERIOD_ROM[i];
			end else begin
				tmp = {1'b0, tbl[i - 12]} + 18'd1;
				tbl[i] = tmp[17:1];
			end
		end
		return tbl;
	endfunction

	localparam period_tbl_t PERIODS = build_periods();

endpackage

>>> hw/rtl/polyphonic_square_adsr_synth_core.sv
// Note event: no result; the core stays in ST_IDLE, ready for the next item.
// Tick: per voice, ST_PREP, ST_MUL, ST_DSTART, ST_DWAIT (on the shared radix-2
// divider), ST_SQ, ST_ACC; then ST_OUT, which stalls while the output register
// holds an unsent sample. One item at a time: input is taken only in ST_IDLE.
// A finished sample waits in the output register while the next item is taken.
// arst_n clears all voices, the sample clock and the output, and loads the
// register defaults.
module polyphonic_square_adsr_synth_core #(
	parameter int unsigned VOICES = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [4:0] note_index, [5] key_down
	input  logic        s_tuser,  // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [18:0] sample_out
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	import psa_pkg::*;

	localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam logic [VW-1:0] LAST = VW'(VOICES - 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_MUL, ST_DSTART, ST_DWAIT, ST_SQ, ST_ACC, ST_OUT
	} state_t;

	state_t state_q;

	logic [19:0] attack_q, decay_q, release_q;
	logic [15:0] sustain_q;
	logic [31:0] clock_q;
	logic [VW-1:0] vcnt_q;

	logic [15:0] mula_q, base_q;
	logic [20:0] mulb_q;
	logic [19:0] den_q;
	logic [36:0] prod_q;
	logic [14:0] mag_q;
	logic signed [20:0] sum_q;
	logic        out_valid_q;
	logic [18:0] out_data_q;

	voice_t ring [VOICES];
	voice_t head, tail;
	logic   s_fire;
	logic   shift;
	logic   div_done;
	logic [15:0] quo;

	logic [15:0] s_cap;
	logic [31:0] t;
	logic [20:0] ad;
	logic [16:0] level;
	logic [31:0] sq;
	logic [17:0] ph1, ph2;
	logic [16:0] ph_new;
	period_t     per;
	logic        neg;
	logic signed [20:0] sum_next;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign shift    = (state_q == ST_ACC);
	assign head     = ring[0];

	assign s_cap = (sustain_q > FULL_SCALE) ? FULL_SCALE : sustain_q;
	assign t     = clock_q - head.trig;
	assign ad    = {1'b0, attack_q} + {1'b0, decay_q};

	assign per    = PERIODS[vcnt_q];
	assign ph1    = {1'b0, head.phase} + PHASE_STEP;
	assign ph2    = (ph1 > {1'b0, per}) ? (ph1 - {1'b0, per}) : ph1;
	assign ph_new = ph2[16:0];
	assign neg    = ({ph_new, 1'b0} >= {1'b0, per});
	assign tail   = '{held: head.held, trig: head.trig, phase: ph_new};

	assign level = {1'b0, base_q} + {1'b0, quo};
	assign sq    = level[15:0] * level[15:0];

	assign sum_next = neg ? (sum_q - 21'(mag_q)) : (sum_q + 21'(mag_q));

	for (genvar i = 0; i < VOICES; i++) begin : g_cell
		voice_t din;
		logic   we;
		if (i == VOICES - 1) begin : g_tail
			assign din = tail;
		end else begin : g_mid
			assign din = ring[i + 1];
		end
		assign we = s_fire && (s_tuser == KIND_NOTE) && (32'(s_tdata[4:0]) == i);
		psa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (shift),
			.din      (din),
			.note_we  (we),
			.key_down (s_tdata[5]),
			.clk_now  (clock_q),
			.dout     (ring[i])
		);
	end

	psa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DSTART),
		.num    (prod_q[35:0]),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= 20'd16000;
			decay_q   <= 20'd3200;
			sustain_q <= 16'd24576;
			release_q <= 20'd8000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATTACK:  attack_q  <= cfg_data;
				REG_DECAY:   decay_q   <= cfg_data;
				REG_SUSTAIN: sustain_q <= cfg_data[15:0];
				REG_RELEASE: release_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP: begin
				if (head.held) begin
					if (t < 32'(attack_q)) begin
						mula_q <= FULL_SCALE;
						mulb_q <= t[20:0];
						base_q <= '0;
						den_q  <= attack_q;
					end else if (t < 32'(ad)) begin
						mula_q <= FULL_SCALE - s_cap;
						mulb_q <= ad - t[20:0];
						base_q <= s_cap;
						den_q  <= decay_q;
					end else begin
						mula_q <= '0;
						mulb_q <= '0;
						base_q <= s_cap;
						den_q  <= 20'd1;
					end
				end else if (t < 32'(release_q)) begin
					mula_q <= s_cap;
					mulb_q <= {1'b0, release_q} - t[20:0];
					base_q <= '0;
					den_q  <= release_q;
				end else begin
					mula_q <= '0;
					mulb_q <= '0;
					base_q <= '0;
					den_q  <= 20'd1;
				end
			end
			ST_MUL: prod_q <= mula_q * mulb_q;
			ST_SQ:  mag_q  <= sq[31:17];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clock_q     <= '0;
			vcnt_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && m_tready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire && (s_tuser == KIND_TICK)) begin
						vcnt_q  <= '0;
						sum_q   <= '0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP:   state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: state_q <= ST_ACC;
				ST_ACC: begin
					sum_q <= sum_next;
					if (vcnt_q == LAST) begin
						clock_q <= clock_q + 32'd1;
						state_q <= ST_OUT;
					end else begin
						vcnt_q  <= vcnt_q + VW'(1);
						state_q <= ST_PREP;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						if (sum_q > OUT_MAX) begin
							out_data_q <= OUT_MAX[18:0];
						end else if (sum_q < OUT_MIN) begin
							out_data_q <= OUT_MIN[18:0];
						end else begin
							out_data_q <= sum_q[18:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_data_q};

endmodule

>>> hw/rtl/psa_cell.sv
module psa_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  psa_pkg::voice_t din,
	input  logic            note_we,
	input  logic            key_down,
	input  logic [31:0]     clk_now,
	output psa_pkg::voice_t dout
);
	import psa_pkg::*;

	voice_t voice_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_q <= '0;
		end else if (note_we) begin
			if (voice_q.held != key_down) begin
				voice_q.held <= key_down;
				voice_q.trig <= clk_now;
			end
		end else if (shift) begin
			voice_q <= din;
		end
	end

	assign dout = voice_q;

endmodule

>>> hw/rtl/psa_div.sv
module psa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [35:0] num,
	input  logic [19:0] den,
	output logic        done,
	output logic [15:0] quo
);
	import psa_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [19:0] rem_q;
	logic [15:0] quo_q;
	logic [19:0] den_q;
	logic [20:0] sh;
	logic [20:0] diff;

	assign sh   = {rem_q, quo_q[15]};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 5'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[35:16];
			quo_q <= num[15:0];
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[20]) begin
				rem_q <= diff[19:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= sh[19:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> hw/rtl/psa_checker.sv
module psa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	import psa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output dropped or changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:19] == 5'd0)
		else $error("output padding not zero");

	a_note_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_NOTE && !m_tvalid |=> !m_tvalid)
		else $error("note event produced a sample");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_TICK |=> !s_tready)
		else $error("input taken while a tick is in progress");

endmodule

bind polyphonic_square_adsr_synth_core psa_checker u_psa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
